### rtl/sqvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqvt_pkg: shared constants and types for the sprite quad vertex transform.
// Holds fixed-point formats, sine polynomial constants and pipeline widths.
// ----------------------------------------------------------------------------
package sqvt_pkg;

  localparam int unsigned COORD_FRAC_BITS = 4;
  localparam int unsigned ANGLE_BITS      = 12;
  localparam int unsigned SCALE_FRAC_BITS = 12;

  // The corner is kept with one extra fractional bit because it is built from
  // the full size rather than the half size.
  localparam int unsigned CORNER_FRAC = SCALE_FRAC_BITS + 1;
  localparam int unsigned TRIG_FRAC   = 14;

  localparam int unsigned QUARTER = 1 << (ANGLE_BITS - 2);

  // Sine polynomial coefficients, Q16.
  localparam logic [16:0] SIN_C1 = 17'd102944;
  localparam logic [15:0] SIN_C3 = 16'd42047;
  localparam logic [12:0] SIN_C5 = 13'd4640;
  localparam logic [14:0] SIN_MAX = 15'd16384;

  // Datapath widths.
  localparam int unsigned SZW  = 32;                    // size times scale
  localparam int unsigned PRW  = SZW + 1 + 16;          // product with a Q14 trig value
  localparam int unsigned SUMW = PRW + 1;               // sum of two products
  localparam int unsigned PXW  = SUMW - TRIG_FRAC;      // rotated corner
  localparam int unsigned QPW  = PXW + 16;              // product with tilt cosine
  localparam int unsigned QXW  = QPW - TRIG_FRAC;       // final corner
  localparam int unsigned CRW  = QXW - CORNER_FRAC;     // corner in 12.4 units
  localparam int unsigned BASW = 18;                    // origin plus centre
  localparam int unsigned VXW  = CRW + 1;               // vertex before clamp

  localparam int signed ORIGIN = 2048 << COORD_FRAC_BITS;

  localparam int unsigned NUM_CORNERS = 4;
  localparam logic [1:0]  LAST_CORNER = 2'd3;

  // Per-stage load enables of the sine pipeline.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } sqvt_adv_t;

endpackage

`default_nettype wire

### rtl/sprite_quad_vertex_transform_top.sv
`default_nettype none
// A sprite's first vertex beat is offered from the vertex buffer, after stages 1 to 7.
// The vertex buffer takes a sprite when empty or as the last of its four beats is taken.
// The arithmetic pipeline takes a sprite every cycle unless stalled by the serializer.
// Reset clears the stage valid bits, the serializer state and the beat counter.
// Data registers are not reset.
// ----------------------------------------------------------------------------
// sprite_quad_vertex_transform_top: rotated, scaled sprite quad vertex setup.
// Turns one sprite beat into four vertex beats with bounding half-extents.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_transform_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] centre_x_i,
  input  wire logic signed [15:0] centre_y_i,
  input  wire logic [31:0]        depth_i,
  input  wire logic [15:0]        sprite_width_i,
  input  wire logic [15:0]        sprite_height_i,
  input  wire logic [15:0]        scale_x_i,
  input  wire logic [15:0]        scale_y_i,
  input  wire logic [11:0]        spin_angle_i,
  input  wire logic [11:0]        tilt_about_x_i,
  input  wire logic [11:0]        tilt_about_y_i,
  input  wire logic [31:0]        colour_rgba_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [15:0]             vertex_x_o,
  output logic [15:0]             vertex_y_o,
  output logic [31:0]             vertex_depth_o,
  output logic [31:0]             vertex_colour_o,
  output logic [1:0]              corner_number_o,
  output logic                    last_corner_o,
  output logic signed [15:0]      bound_half_width_o,
  output logic signed [15:0]      bound_half_height_o
);

  localparam int unsigned NC   = sqvt_pkg::NUM_CORNERS;
  localparam int unsigned AB   = sqvt_pkg::ANGLE_BITS;
  localparam int unsigned PRW  = sqvt_pkg::PRW;
  localparam int unsigned SUMW = sqvt_pkg::SUMW;
  localparam int unsigned PXW  = sqvt_pkg::PXW;
  localparam int unsigned QPW  = sqvt_pkg::QPW;
  localparam int unsigned QXW  = sqvt_pkg::QXW;
  localparam int unsigned CRW  = sqvt_pkg::CRW;
  localparam int unsigned VXW  = sqvt_pkg::VXW;
  localparam int unsigned BASW = sqvt_pkg::BASW;
  localparam int unsigned SZW  = sqvt_pkg::SZW;

  // Stage valid bits: index 0 is stage 1, index 6 is stage 7.
  logic [6:0] vld_q;
  // Load enables: index 7 is the vertex serializer buffer.
  logic [7:0] rdy;

  logic              ov_q;
  logic [1:0]        cnt_q;
  logic              beat_done;

  // Payload that travels with the sprite.
  logic signed [15:0] cx_q [7];
  logic signed [15:0] cy_q [7];
  logic [31:0]        dep_q [7];
  logic [31:0]        col_q [7];
  logic [SZW-1:0]     wsc_q [4];
  logic [SZW-1:0]     hsc_q [4];

  logic signed [15:0] sin_z, cos_z, cos_xt, cos_yt;
  logic signed [15:0] cxt_q [2];
  logic signed [15:0] cyt_q [2];

  logic signed [PRW-1:0] wcz_q, hsz_q, wsz_q, hcz_q;
  logic signed [PXW-1:0] px_q [NC];
  logic signed [PXW-1:0] py_q [NC];
  logic signed [QXW-1:0] qx_q [NC];
  logic signed [QXW-1:0] qy_q [NC];

  logic [15:0]        obx_q [NC];
  logic [15:0]        oby_q [NC];
  logic [31:0]        odep_q, ocol_q;
  logic signed [15:0] obw_q, obh_q;

  sqvt_pkg::sqvt_adv_t adv;

  // --------------------------------------------------------------------------
  // Handshake: a stage loads when it is empty or its contents move on.
  // --------------------------------------------------------------------------
  assign beat_done = ov_q && !out_stall_i;

  always_comb begin
    rdy[7] = !ov_q || (beat_done && (cnt_q == sqvt_pkg::LAST_CORNER));
    for (int k = 6; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[0];
  assign adv = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < 7; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
      if (rdy[7]) ov_q <= vld_q[6];
      if (beat_done) cnt_q <= cnt_q + 2'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 1 to 4: four sine pipelines; cosine is sine a quarter turn later.
  // --------------------------------------------------------------------------
  logic [AB-1:0] ang_cz, ang_cx, ang_cy;
  assign ang_cz = spin_angle_i[AB-1:0] + AB'(sqvt_pkg::QUARTER);
  assign ang_cx = tilt_about_x_i[AB-1:0] + AB'(sqvt_pkg::QUARTER);
  assign ang_cy = tilt_about_y_i[AB-1:0] + AB'(sqvt_pkg::QUARTER);

  sqvt_sine u_sin_z  (.clk_i(clk_i), .adv_i(adv), .angle_i(spin_angle_i[AB-1:0]),
                      .sin_o(sin_z));
  sqvt_sine u_cos_z  (.clk_i(clk_i), .adv_i(adv), .angle_i(ang_cz), .sin_o(cos_z));
  sqvt_sine u_cos_xt (.clk_i(clk_i), .adv_i(adv), .angle_i(ang_cx), .sin_o(cos_xt));
  sqvt_sine u_cos_yt (.clk_i(clk_i), .adv_i(adv), .angle_i(ang_cy), .sin_o(cos_yt));

  // Payload delay line, with the size-times-scale products formed in stage 1.
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      cx_q[0]  <= centre_x_i;
      cy_q[0]  <= centre_y_i;
      dep_q[0] <= depth_i;
      col_q[0] <= colour_rgba_i;
      wsc_q[0] <= sprite_width_i * scale_x_i;
      hsc_q[0] <= sprite_height_i * scale_y_i;
    end
    for (int k = 1; k < 7; k++) begin
      if (rdy[k]) begin
        cx_q[k]  <= cx_q[k-1];
        cy_q[k]  <= cy_q[k-1];
        dep_q[k] <= dep_q[k-1];
        col_q[k] <= col_q[k-1];
      end
    end
    for (int k = 1; k < 4; k++) begin
      if (rdy[k]) begin
        wsc_q[k] <= wsc_q[k-1];
        hsc_q[k] <= hsc_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: products of the full size and the spin sine and cosine.
  // Stage 6: per-corner rotation sums, floored to the trig precision.
  // Stage 7: tilt cosine scaling.
  // --------------------------------------------------------------------------
  logic signed [SZW:0]    wsc_s, hsc_s;
  logic signed [SUMW-1:0] sumx [NC];
  logic signed [SUMW-1:0] sumy [NC];
  logic signed [QPW-1:0]  prx [NC];
  logic signed [QPW-1:0]  pry [NC];

  assign wsc_s = $signed({1'b0, wsc_q[3]});
  assign hsc_s = $signed({1'b0, hsc_q[3]});

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      // Corners 0 and 1 sit on the left, corners 0 and 2 on the top.
      logic signed [SUMW-1:0] ax, ay, bx, by;
      ax = (k >= 2) ? SUMW'(wcz_q) : -SUMW'(wcz_q);
      ay = (k >= 2) ? SUMW'(wsz_q) : -SUMW'(wsz_q);
      bx = (k % 2 == 1) ? SUMW'(hsz_q) : -SUMW'(hsz_q);
      by = (k % 2 == 1) ? SUMW'(hcz_q) : -SUMW'(hcz_q);
      sumx[k] = ax - bx;
      sumy[k] = ay + by;
      prx[k]  = px_q[k] * cyt_q[1];
      pry[k]  = py_q[k] * cxt_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      wcz_q    <= wsc_s * cos_z;
      hsz_q    <= hsc_s * sin_z;
      wsz_q    <= wsc_s * sin_z;
      hcz_q    <= hsc_s * cos_z;
      cxt_q[0] <= cos_xt;
      cyt_q[0] <= cos_yt;
    end
    if (rdy[5]) begin
      cxt_q[1] <= cxt_q[0];
      cyt_q[1] <= cyt_q[0];
      for (int k = 0; k < NC; k++) begin
        px_q[k] <= PXW'(sumx[k] >>> sqvt_pkg::TRIG_FRAC);
        py_q[k] <= PXW'(sumy[k] >>> sqvt_pkg::TRIG_FRAC);
      end
    end
    if (rdy[6]) begin
      for (int k = 0; k < NC; k++) begin
        qx_q[k] <= QXW'(prx[k] >>> sqvt_pkg::TRIG_FRAC);
        qy_q[k] <= QXW'(pry[k] >>> sqvt_pkg::TRIG_FRAC);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: bounding maxima, origin offset and saturation, into the vertex
  // buffer that the serializer drains one corner per beat.
  // --------------------------------------------------------------------------
  logic signed [QXW-1:0]  mx01, mx23, my01, my23, mxa, mya;
  logic signed [CRW-1:0]  mxc, myc;
  logic signed [BASW-1:0] basex, basey;
  logic signed [VXW-1:0]  vx [NC];
  logic signed [VXW-1:0]  vy [NC];
  logic [15:0]            vxs [NC];
  logic [15:0]            vys [NC];
  logic signed [15:0]     bw, bh;

  function automatic logic [15:0] sat_u16(input logic signed [VXW-1:0] v);
    if (v < 0) return 16'd0;
    if (v > VXW'(65535)) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sat_s16(input logic signed [CRW-1:0] v);
    if (v < CRW'(-32768)) return 16'sh8000;
    if (v > CRW'(32767)) return 16'sh7FFF;
    return v[15:0];
  endfunction

  always_comb begin
    mx01  = (qx_q[1] > qx_q[0]) ? qx_q[1] : qx_q[0];
    mx23  = (qx_q[3] > qx_q[2]) ? qx_q[3] : qx_q[2];
    my01  = (qy_q[1] > qy_q[0]) ? qy_q[1] : qy_q[0];
    my23  = (qy_q[3] > qy_q[2]) ? qy_q[3] : qy_q[2];
    mxa   = (mx23 > mx01) ? mx23 : mx01;
    mya   = (my23 > my01) ? my23 : my01;
    mxc   = CRW'(mxa >>> sqvt_pkg::CORNER_FRAC);
    myc   = CRW'(mya >>> sqvt_pkg::CORNER_FRAC);
    bw    = sat_s16(mxc);
    bh    = sat_s16(myc);
    basex = BASW'(sqvt_pkg::ORIGIN) + BASW'(cx_q[6]);
    basey = BASW'(sqvt_pkg::ORIGIN) + BASW'(cy_q[6]);
    for (int k = 0; k < NC; k++) begin
      vx[k]  = VXW'(basex) + VXW'(qx_q[k] >>> sqvt_pkg::CORNER_FRAC);
      vy[k]  = VXW'(basey) + VXW'(qy_q[k] >>> sqvt_pkg::CORNER_FRAC);
      vxs[k] = sat_u16(vx[k]);
      vys[k] = sat_u16(vy[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      for (int k = 0; k < NC; k++) begin
        obx_q[k] <= vxs[k];
        oby_q[k] <= vys[k];
      end
      odep_q <= dep_q[6];
      ocol_q <= col_q[6];
      obw_q  <= bw;
      obh_q  <= bh;
    end
  end

  assign out_valid_o         = ov_q;
  assign vertex_x_o          = obx_q[cnt_q];
  assign vertex_y_o          = oby_q[cnt_q];
  assign vertex_depth_o      = odep_q;
  assign vertex_colour_o     = ocol_q;
  assign corner_number_o     = cnt_q;
  assign last_corner_o       = (cnt_q == sqvt_pkg::LAST_CORNER);
  assign bound_half_width_o  = obw_q;
  assign bound_half_height_o = obh_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // A sprite's four beats are never split by a gap in valid.
  a_beats_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_corner_o |=> out_valid_o)
    else $error("vertex beats of one sprite were interrupted");

  // After the last corner the next sprite starts at corner zero.
  a_corner_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_corner_o |=> corner_number_o == 2'd0)
    else $error("corner counter did not wrap after the last corner");

  // An empty first stage never pushes back on the input.
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  // The corner counter only moves while a vertex is being delivered.
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> corner_number_o == 2'd0)
    else $error("corner counter nonzero with no vertex pending");

endmodule

`default_nettype wire

### rtl/sqvt_sine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sqvt_sine: four-stage pipelined sine, Q14 output.
// Folds the angle to a quarter wave and evaluates an odd polynomial.
// ----------------------------------------------------------------------------
module sqvt_sine (
  input  wire logic                                clk_i,
  input  wire sqvt_pkg::sqvt_adv_t                 adv_i,
  input  wire logic [sqvt_pkg::ANGLE_BITS-1:0]     angle_i,
  output logic signed [15:0]                       sin_o
);

  localparam int unsigned AB = sqvt_pkg::ANGLE_BITS;

  logic [1:0]    quad;
  logic [AB-3:0] rem;
  logic [AB-2:0] xq;
  logic [16:0]   x16;
  logic [33:0]   sq1;
  logic [29:0]   pr2;
  logic [32:0]   pr3;
  logic [33:0]   pr4;
  logic [18:0]   rnd4;
  logic [16:0]   q4;
  logic [14:0]   qc4;

  logic [16:0] x16_1_q, x2_1_q, x16_2_q, x2_2_q, x16_3_q;
  logic [15:0] t_2_q;
  logic [16:0] p_3_q;
  logic        neg_1_q, neg_2_q, neg_3_q;
  logic signed [15:0] sin_q;

  always_comb begin
    quad = angle_i[AB-1:AB-2];
    rem  = angle_i[AB-3:0];
    xq   = quad[0] ? (AB-1)'(sqvt_pkg::QUARTER - {1'b0, rem}) : {1'b0, rem};
    x16  = 17'(xq) << (18 - AB);
    sq1  = x16 * x16;
    pr2  = sqvt_pkg::SIN_C5 * x2_1_q;
    pr3  = t_2_q * x2_2_q;
    pr4  = p_3_q * x16_3_q;
    rnd4 = {1'b0, pr4[33:16]} + 19'd2;
    q4   = rnd4[18:2];
    qc4  = (q4 > 17'(sqvt_pkg::SIN_MAX)) ? sqvt_pkg::SIN_MAX : q4[14:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      x16_1_q <= x16;
      x2_1_q  <= sq1[32:16];
      neg_1_q <= quad[1];
    end
    if (adv_i.s2) begin
      x16_2_q <= x16_1_q;
      x2_2_q  <= x2_1_q;
      t_2_q   <= sqvt_pkg::SIN_C3 - {2'b0, pr2[29:16]};
      neg_2_q <= neg_1_q;
    end
    if (adv_i.s3) begin
      x16_3_q <= x16_2_q;
      p_3_q   <= sqvt_pkg::SIN_C1 - pr3[32:16];
      neg_3_q <= neg_2_q;
    end
    if (adv_i.s4) begin
      sin_q <= neg_3_q ? -$signed({1'b0, qc4}) : $signed({1'b0, qc4});
    end
  end

  assign sin_o = sin_q;

endmodule

`default_nettype wire
